// ===== hdl/mrme_pkg.sv =====
`default_nettype none
package mrme_pkg;

    localparam int MAX_STATES = 8;
    localparam int ST_W       = 3;
    localparam int CNT_W      = 4;
    localparam int ADDR_W     = 2 * ST_W;
    localparam int DEPTH      = MAX_STATES * MAX_STATES;
    localparam int ACC_W      = 48;
    localparam int AMT_W      = 32;
    localparam int SUM_W      = 51;
    localparam int RATE_W     = 48;
    localparam int FL_W       = 24;
    localparam int FRAC_SH    = 24;
    localparam int DIV_STEPS  = 48;
    localparam int STEP_W     = 6;

    localparam logic [ACC_W-1:0]  ACC_MAX = {ACC_W{1'b1}};
    localparam logic [RATE_W-2:0] MAG_MAX = {(RATE_W-1){1'b1}};
    localparam logic [RATE_W-1:0] NEG_MIN = {1'b1, {(RATE_W-1){1'b0}}};

    typedef enum logic [1:0] {
        ACT_DWELL = 2'd0,
        ACT_TRANS = 2'd1,
        ACT_EST   = 2'd2,
        ACT_CLEAR = 2'd3
    } t_action;

    typedef enum logic {
        CFG_NUM_STATES = 1'b0,
        CFG_RATE_FLOOR = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic              ovf;
        logic [ACC_W-1:0]  quot;
    } t_div_res;

endpackage
`default_nettype wire

// ===== hdl/markov_rate_matrix_estimator.sv =====
`default_nettype none
// Rate-matrix estimator for a continuous-time Markov chain.
// Input channel (i_valid/o_ready) takes one item: add dwell, add transition,
// estimate a row, or clear the statistics table. Output channel (o_valid/i_ready)
// returns the rates of an estimated row, one item per column, o_last on the
// final column. Configuration is a plain write port (i_cfg_we, i_cfg_idx,
// i_cfg_data): index 0 is the state count, index 1 the rate floor.
// A clear or an ignored item is done in the idle state; dwell and transition
// items pass through accept, memory read and read-modify-write.
// An estimate of n states reads the row entry by entry, then, unless the row
// has no dwell, makes one pass of the shared restoring divider (start, 48
// quotient steps, result) for each off-diagonal entry and one for the
// diagonal, floors the rates (whole row at once if the diagonal is under the
// floor) and outputs them; the divider makes one quotient bit per cycle.
// Items are worked one at a time; o_ready is high only when idle.
// Results sit in an output register, so a new item is accepted while the
// last column still waits; a stalled receiver holds the row part way.
// Reset clears the table (by valid bits, no clearing pass), sets the state
// count to 8 and the rate floor to 17, and drops any pending result.
module markov_rate_matrix_estimator (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_idx,
    input  wire logic [mrme_pkg::FL_W-1:0]     i_cfg_data,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [1:0]                    i_action,
    input  wire logic [mrme_pkg::ST_W-1:0]     i_from_state,
    input  wire logic [mrme_pkg::ST_W-1:0]     i_to_state,
    input  wire logic [mrme_pkg::AMT_W-1:0]    i_amount,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic      [mrme_pkg::ST_W-1:0]     o_column,
    output logic signed [mrme_pkg::RATE_W-1:0] o_rate,
    output logic                               o_last
);
    import mrme_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_ARD  = 10'b0000000010,
        S_AWR  = 10'b0000000100,
        S_RRD  = 10'b0000001000,
        S_RCAP = 10'b0000010000,
        S_DIV  = 10'b0000100000,
        S_DWT  = 10'b0001000000,
        S_FLR  = 10'b0010000000,
        S_FL   = 10'b0100000000,
        S_OUT  = 10'b1000000000
    } t_state;

    t_state r_state;

    // configuration
    logic [CNT_W-1:0] r_numst;
    logic [FL_W-1:0]  r_fl;

    // item under work
    logic [ST_W-1:0]   r_from;
    logic [ADDR_W-1:0] r_addr;
    logic [AMT_W-1:0]  r_amt;
    logic [CNT_W-1:0]  r_n;
    logic [CNT_W-1:0]  r_j;

    // row working set
    logic [ACC_W-1:0]    r_cnt  [MAX_STATES];
    logic [RATE_W-2:0]   r_offm [MAX_STATES];
    logic [ACC_W-1:0]    r_tot;
    logic [SUM_W-1:0]    r_numtr;
    logic [RATE_W-1:0]   r_diagm;

    // output register
    logic              r_ovld;
    logic [ST_W-1:0]   r_ocol;
    logic [RATE_W-1:0] r_orate;
    logic              r_olast;

    logic [CNT_W-1:0]  n_sel;
    logic              accept;
    logic              mem_clr;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_raddr;
    logic [ACC_W-1:0]  mem_rdata;
    logic [ACC_W:0]    acc_sum;
    logic [ACC_W-1:0]  acc_sat;
    logic              div_start;
    logic [SUM_W-1:0]  div_num;
    t_div_res          div_res;
    logic [CNT_W-1:0]  j_next;
    logic              j_end;
    logic [ST_W-1:0]   j_idx;
    logic [ACC_W-1:0]  tot_now;
    logic [26:0]       fl_nm1;
    logic [RATE_W:0]   diag_add;
    logic [RATE_W-2:0] off_sat;
    logic [RATE_W-1:0] diag_sat;
    logic              j_is_diag;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    // clamp the state count into its legal range
    always_comb begin
        priority if (r_numst < CNT_W'(2)) begin
            n_sel = CNT_W'(2);
        end else if (r_numst > CNT_W'(MAX_STATES)) begin
            n_sel = CNT_W'(MAX_STATES);
        end else begin
            n_sel = r_numst;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_numst <= CNT_W'(8);
            r_fl    <= FL_W'(17);
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_NUM_STATES: r_numst <= i_cfg_data[CNT_W-1:0];
                CFG_RATE_FLOOR: r_fl    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign j_idx     = r_j[ST_W-1:0];
    assign j_end     = (r_j == r_n - 1'b1);
    assign j_next    = j_end ? CNT_W'(MAX_STATES) : r_j + 1'b1;
    assign j_is_diag = (j_idx == r_from);

    assign mem_clr   = accept && (t_action'(i_action) == ACT_CLEAR);
    assign mem_we    = (r_state == S_AWR);
    assign mem_raddr = (r_state == S_RRD) ? {r_from, j_idx} : r_addr;
    assign acc_sum   = {1'b0, mem_rdata} + (ACC_W+1)'(r_amt);
    assign acc_sat   = acc_sum[ACC_W] ? ACC_MAX : acc_sum[ACC_W-1:0];

    mrme_mem u_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (mem_clr),
        .i_we    (mem_we),
        .i_waddr (r_addr),
        .i_wdata (acc_sat),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // numerator: summed counts for the diagonal, else the entry of this column
    assign div_num   = (r_j == CNT_W'(MAX_STATES)) ? r_numtr : SUM_W'(r_cnt[j_idx]);
    assign div_start = (r_state == S_DIV) &&
                       ((r_j == CNT_W'(MAX_STATES)) || !j_is_diag);

    mrme_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_tot),
        .o_res   (div_res)
    );

    assign off_sat  = (div_res.ovf || div_res.quot > ACC_W'(MAG_MAX)) ?
                      MAG_MAX : div_res.quot[RATE_W-2:0];
    assign diag_sat = (div_res.ovf || div_res.quot > NEG_MIN) ? NEG_MIN : div_res.quot;
    assign tot_now  = j_is_diag ? mem_rdata : r_tot;
    assign fl_nm1   = r_fl * 3'(r_n - 1'b1);
    assign diag_add = {1'b0, r_diagm} + (RATE_W+1)'(r_fl);

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovld  <= 1'b0;
        end else begin
            // load the next column, or drop an item the receiver has taken
            if (r_state == S_OUT && (!r_ovld || i_ready)) begin
                r_ovld <= 1'b1;
            end else if (i_ready) begin
                r_ovld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept && t_action'(i_action) != ACT_CLEAR &&
                        CNT_W'(i_from_state) < n_sel) begin
                        unique case (t_action'(i_action))
                            ACT_DWELL: r_state <= S_ARD;
                            ACT_TRANS: begin
                                if (CNT_W'(i_to_state) < n_sel &&
                                    i_to_state != i_from_state) begin
                                    r_state <= S_ARD;
                                end
                            end
                            ACT_EST:   r_state <= S_RRD;
                            default: ;
                        endcase
                    end
                end
                S_ARD:  r_state <= S_AWR;
                S_AWR:  r_state <= S_IDLE;
                S_RRD:  r_state <= S_RCAP;
                S_RCAP: begin
                    if (!j_end) begin
                        r_state <= S_RRD;
                    end else if (tot_now == '0) begin
                        r_state <= S_FLR;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_start) begin
                        r_state <= S_DWT;
                    end
                end
                S_DWT: begin
                    if (div_res.done) begin
                        r_state <= (r_j == CNT_W'(MAX_STATES)) ? S_FLR : S_DIV;
                    end
                end
                S_FLR:  r_state <= (r_diagm < RATE_W'(r_fl)) ? S_OUT : S_FL;
                S_FL: begin
                    if (j_end) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if ((!r_ovld || i_ready) && j_end) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // working registers, no reset needed
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_from  <= i_from_state;
                r_amt   <= i_amount;
                r_n     <= n_sel;
                r_j     <= '0;
                r_numtr <= '0;
                r_addr  <= (t_action'(i_action) == ACT_DWELL) ?
                           {i_from_state, i_from_state} : {i_from_state, i_to_state};
            end
            S_RCAP: begin
                r_cnt[j_idx] <= mem_rdata;
                if (j_is_diag) begin
                    r_tot <= mem_rdata;
                end else begin
                    r_numtr <= r_numtr + SUM_W'(mem_rdata);
                end
                if (!j_end) begin
                    r_j <= r_j + 1'b1;
                end else if (tot_now == '0) begin
                    // no dwell: every rate takes the floor
                    for (int k = 0; k < MAX_STATES; k++) begin
                        r_offm[k] <= (RATE_W-1)'(r_fl);
                    end
                    r_diagm <= RATE_W'(fl_nm1);
                end else begin
                    r_j <= '0;
                end
            end
            S_DIV: begin
                // skip the diagonal column, its rate comes from the summed counts
                if (!div_start) begin
                    r_j <= j_next;
                end
            end
            S_DWT: begin
                if (div_res.done) begin
                    if (r_j == CNT_W'(MAX_STATES)) begin
                        r_diagm <= diag_sat;
                        r_j     <= '0;
                    end else begin
                        r_offm[j_idx] <= off_sat;
                        r_j           <= j_next;
                    end
                end
            end
            S_FLR: begin
                r_j <= '0;
                if (r_diagm < RATE_W'(r_fl)) begin
                    for (int k = 0; k < MAX_STATES; k++) begin
                        r_offm[k] <= (RATE_W-1)'(r_fl);
                    end
                    r_diagm <= RATE_W'(fl_nm1);
                end
            end
            S_FL: begin
                if (!j_is_diag && r_offm[j_idx] < (RATE_W-1)'(r_fl)) begin
                    r_offm[j_idx] <= (RATE_W-1)'(r_fl);
                    r_diagm <= (diag_add > (RATE_W+1)'(NEG_MIN)) ?
                               NEG_MIN : diag_add[RATE_W-1:0];
                end
                r_j <= j_end ? '0 : r_j + 1'b1;
            end
            S_OUT: begin
                if (!r_ovld || i_ready) begin
                    r_ocol  <= j_idx;
                    r_orate <= j_is_diag ? RATE_W'(0) - r_diagm : {1'b0, r_offm[j_idx]};
                    r_olast <= j_end;
                    r_j     <= r_j + 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign o_valid  = r_ovld;
    assign o_column = r_ocol;
    assign o_rate   = r_orate;
    assign o_last   = r_olast;

    // divider is started only when it is free
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> !div_res.busy)
        else $error("divider restarted while busy");

    // a table write never meets a clear
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we |-> !mem_clr)
        else $error("table write during clear");

    // a quotient only completes while the sequencer waits for it
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_res.done |-> (r_state == S_DWT))
        else $error("divider result with no consumer");

endmodule
`default_nettype wire

// ===== hdl/mrme_mem.sv =====
`default_nettype none
module mrme_mem (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_clr,
    input  wire logic                         i_we,
    input  wire logic [mrme_pkg::ADDR_W-1:0]  i_waddr,
    input  wire logic [mrme_pkg::ACC_W-1:0]   i_wdata,
    input  wire logic [mrme_pkg::ADDR_W-1:0]  i_raddr,
    output logic      [mrme_pkg::ACC_W-1:0]   o_rdata
);
    import mrme_pkg::*;

    logic [ACC_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_vld;
    logic [ACC_W-1:0] r_rd;
    logic             r_rdv;

    // storage: written and read at one address each per cycle
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rd <= r_mem[i_raddr];
    end

    // entry valid bits; a clear drops them all at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_vld <= '0;
            r_rdv <= 1'b0;
        end else begin
            if (i_we) begin
                r_vld[i_waddr] <= 1'b1;
            end
            r_rdv <= r_vld[i_raddr];
        end
    end

    assign o_rdata = r_rdv ? r_rd : '0;

endmodule
`default_nettype wire

// ===== hdl/mrme_div.sv =====
`default_nettype none
module mrme_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [mrme_pkg::SUM_W-1:0]  i_num,
    input  wire logic [mrme_pkg::ACC_W-1:0]  i_den,
    output mrme_pkg::t_div_res               o_res
);
    import mrme_pkg::*;

    logic              r_busy;
    logic              r_done;
    logic              r_ovf;
    logic [STEP_W-1:0] r_step;
    logic [ACC_W-1:0]  r_rem;
    logic [ACC_W-1:0]  r_lo;
    logic [ACC_W-1:0]  r_q;
    logic [ACC_W-1:0]  r_den;
    logic [ACC_W:0]    trial;
    logic              ge;
    logic              big;

    // quotient of num*2^24/den overflows 48 bits when num/2^24 >= den
    assign big   = ACC_W'(i_num[SUM_W-1:FRAC_SH]) >= i_den;
    assign trial = {r_rem, r_lo[ACC_W-1]};
    assign ge    = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_ovf  <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= i_start ? big : (r_busy && (r_step == STEP_W'(DIV_STEPS - 1)));
            if (i_start) begin
                r_ovf  <= big;
                r_busy <= !big;
                r_step <= '0;
            end else if (r_busy) begin
                r_step <= r_step + 1'b1;
                if (r_step == STEP_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // one restoring step a cycle
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= ACC_W'(i_num[SUM_W-1:FRAC_SH]);
            r_lo  <= {i_num[FRAC_SH-1:0], {(ACC_W-FRAC_SH){1'b0}}};
            r_den <= i_den;
            r_q   <= '0;
        end else if (r_busy) begin
            r_rem <= ge ? ACC_W'(trial - {1'b0, r_den}) : trial[ACC_W-1:0];
            r_lo  <= {r_lo[ACC_W-2:0], 1'b0};
            r_q   <= {r_q[ACC_W-2:0], ge};
        end
    end

    assign o_res.busy = r_busy;
    assign o_res.done = r_done;
    assign o_res.ovf  = r_ovf;
    assign o_res.quot = r_q;

endmodule
`default_nettype wire

// ===== sim/mrme_checker.sv =====
`default_nettype none
module mrme_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_idx,
    input  wire logic [mrme_pkg::FL_W-1:0]     i_cfg_data,
    input  wire logic                          i_valid,
    input  wire logic                          i_ready_in,
    input  wire logic [1:0]                    i_action,
    input  wire logic [mrme_pkg::ST_W-1:0]     i_from_state,
    input  wire logic [mrme_pkg::ST_W-1:0]     i_to_state,
    input  wire logic [mrme_pkg::AMT_W-1:0]    i_amount,
    input  wire logic                          i_out_valid,
    input  wire logic                          i_out_ready,
    input  wire logic [mrme_pkg::ST_W-1:0]     i_column,
    input  wire logic [mrme_pkg::RATE_W-1:0]   i_rate,
    input  wire logic                          i_last,
    output int                                 o_errors,
    output int                                 o_pending
);
    import mrme_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [ST_W-1:0]   column;
        logic [RATE_W-1:0] rate;
        logic              last;
    } t_rate_entry;

    logic [ACC_W-1:0] stats [DEPTH];
    logic [CNT_W-1:0] cfg_states;
    logic [FL_W-1:0]  cfg_floor;
    t_rate_entry      rates_due [$];

    assign o_pending = rates_due.size();

    function automatic logic [63:0] q24_quot(logic [63:0] num, logic [63:0] den,
                                             logic [63:0] lim);
        logic [63:0] q;
        logic [63:0] r;
        q = num / den;
        r = num % den;
        if (q >= 64'd1 << 24) return lim;
        for (int k = 0; k < 24; k++) begin
            r = r << 1;
            q = q << 1;
            if (r >= den) begin
                r = r - den;
                q[0] = 1'b1;
            end
        end
        return (q > lim) ? lim : q;
    endfunction

    task automatic accumulate(int idx, logic [AMT_W-1:0] amt);
        logic [63:0] v;
        v = 64'(stats[idx]) + 64'(amt);
        stats[idx] = (v > 64'(ACC_MAX)) ? ACC_MAX : v[ACC_W-1:0];
    endtask

    task automatic apply_item(t_action act, int from, int to, logic [AMT_W-1:0] amt);
        int n;
        logic [63:0] offm [MAX_STATES];
        logic [63:0] diagm, fl, tot, numtr, r;
        t_rate_entry e;
        n = cfg_states < 2 ? 2 : (cfg_states > MAX_STATES ? MAX_STATES : int'(cfg_states));
        if (act == ACT_CLEAR) begin
            foreach (stats[k]) stats[k] = '0;
            return;
        end
        if (from >= n) return;
        if (act == ACT_DWELL) begin
            accumulate(from * MAX_STATES + from, amt);
            return;
        end
        if (act == ACT_TRANS) begin
            if (to < n && to != from) accumulate(from * MAX_STATES + to, amt);
            return;
        end
        fl = 64'(cfg_floor);
        tot = 64'(stats[from * MAX_STATES + from]);
        numtr = 0;
        for (int j = 0; j < n; j++)
            if (j != from) numtr += 64'(stats[from * MAX_STATES + j]);
        if (tot == 0) begin
            for (int j = 0; j < n; j++) offm[j] = fl;
            diagm = fl * 64'(n - 1);
        end else begin
            for (int j = 0; j < n; j++)
                offm[j] = q24_quot(64'(stats[from * MAX_STATES + j]), tot, 64'(MAG_MAX));
            diagm = q24_quot(numtr, tot, 64'(NEG_MIN));
        end
        if (diagm < fl) begin
            for (int j = 0; j < n; j++) offm[j] = fl;
            diagm = fl * 64'(n - 1);
        end else begin
            for (int j = 0; j < n; j++)
                if (j != from && offm[j] < fl) begin
                    offm[j] = fl;
                    diagm += fl;
                    if (diagm > 64'(NEG_MIN)) diagm = 64'(NEG_MIN);
                end
        end
        for (int j = 0; j < n; j++) begin
            r = (j == from) ? (64'd0 - diagm) : offm[j];
            e.column = ST_W'(j);
            e.rate = r[RATE_W-1:0];
            e.last = (j == n - 1);
            rates_due.push_back(e);
        end
    endtask

    always @(posedge i_clk) begin
        t_rate_entry want;
        if (!i_rst_n) begin
            foreach (stats[k]) stats[k] <= '0;
            cfg_states <= CNT_W'(8);
            cfg_floor <= FL_W'(17);
            rates_due.delete();
            o_errors <= 0;
        end else begin
            if (i_cfg_we) begin
                if (t_cfg_idx'(i_cfg_idx) == CFG_NUM_STATES) cfg_states <= i_cfg_data[CNT_W-1:0];
                else cfg_floor <= i_cfg_data;
            end
            // outputs are checked before the new item is applied
            if (i_out_valid && i_out_ready) begin
                if (rates_due.size() == 0) begin
                    $display("%0t: unexpected rate item col=%0d rate=%0h", $realtime,
                             i_column, i_rate);
                    o_errors <= o_errors + 1;
                end else begin
                    want = rates_due.pop_front();
                    if (want.column !== i_column || want.rate !== i_rate
                            || want.last !== i_last) begin
                        $display("%0t: expected col=%0d rate=%0h last=%0b, got col=%0d rate=%0h last=%0b",
                                 $realtime, want.column, want.rate, want.last,
                                 i_column, i_rate, i_last);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_valid && i_ready_in)
                apply_item(t_action'(i_action), int'(i_from_state), int'(i_to_state), i_amount);
        end
    end
endmodule
`default_nettype wire

// ===== sim/tb.sv =====
`default_nettype none
module tb;
    import mrme_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic               i_cfg_idx = 1'b0;
    logic [FL_W-1:0]    i_cfg_data = '0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic [1:0]         i_action = '0;
    logic [ST_W-1:0]    i_from_state = '0;
    logic [ST_W-1:0]    i_to_state = '0;
    logic [AMT_W-1:0]   i_amount = '0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [ST_W-1:0]    o_column;
    logic signed [RATE_W-1:0] o_rate;
    logic               o_last;
    int                 mismatches;
    int                 rates_waiting;
    int                 cycle_count = 0;
    bit                 hold_output = 1'b0;

    markov_rate_matrix_estimator dut (.*);

    mrme_checker u_chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_idx, .i_cfg_data,
        .i_valid, .i_ready_in(o_ready), .i_action, .i_from_state, .i_to_state,
        .i_amount, .i_out_valid(o_valid), .i_out_ready(i_ready),
        .i_column(o_column), .i_rate(o_rate), .i_last(o_last),
        .o_errors(mismatches), .o_pending(rates_waiting)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: estimates take a divider pass per entry, so allow plenty.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 900000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: random stall per item in some stretches, none in others; held off during the long hold-off.
    initial begin
        int gap;
        @(posedge i_clk iff i_rst_n);
        forever begin
            gap = (cycle_count % 3000 < 1000) ? 0 : $urandom_range(0, 14);
            if (gap != 0 || hold_output) begin
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
                while (hold_output) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk iff o_valid);
        end
    end

    // Hold off the output for a long stretch while items keep coming.
    initial begin
        @(posedge i_clk iff cycle_count == 3000);
        hold_output = 1'b1;
        repeat (1500) @(posedge i_clk);
        hold_output = 1'b0;
    end

    // Send one item; wait a random gap first unless no_gap is set, hold valid until accepted.
    task automatic send_item(t_action act, int from, int to, logic [AMT_W-1:0] amt,
                             bit no_gap = 1'b0);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_action <= act;
        i_from_state <= ST_W'(from);
        i_to_state <= ST_W'(to);
        i_amount <= amt;
        @(posedge i_clk iff o_ready);
    endtask

    // Let every row drain, then let any item still in flight finish.
    task automatic drain_rows();
        i_valid <= 1'b0;
        @(posedge i_clk iff rates_waiting == 0);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [FL_W-1:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic logic [AMT_W-1:0] rand_amount();
        case ($urandom_range(0, 5))
            0: return '1;
            1: return '0;
            2: return $urandom_range(1, 255);
            3: return {12'd0, 4'($urandom_range(0, 15)), 16'($urandom)};
            default: return $urandom;
        endcase
    endfunction

    initial begin
        int r;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty-row estimate, saturation, self-transitions, clear.
        send_item(ACT_EST, 0, 0, 0);
        send_item(ACT_DWELL, 7, 0, '1);
        for (int k = 0; k < 6; k++) send_item(ACT_DWELL, 1, 0, '1);
        send_item(ACT_TRANS, 1, 2, '1);
        for (int k = 0; k < 6; k++) send_item(ACT_TRANS, 1, 3, '1);
        send_item(ACT_TRANS, 2, 2, 32'h1234);
        send_item(ACT_EST, 1, 0, 0);
        send_item(ACT_DWELL, 2, 0, 1);
        send_item(ACT_TRANS, 2, 5, '1);
        send_item(ACT_EST, 2, 0, 0);
        send_item(ACT_EST, 7, 0, 0);
        send_item(ACT_CLEAR, 0, 0, 0);
        send_item(ACT_EST, 1, 0, 0);
        drain_rows();

        // Random phases over a range of settings, extremes included.
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: begin
                    write_reg(CFG_NUM_STATES, FL_W'(2));
                    write_reg(CFG_RATE_FLOOR, FL_W'(1));
                end
                1: begin
                    write_reg(CFG_NUM_STATES, FL_W'(0));
                    write_reg(CFG_RATE_FLOOR, 24'hFFFFFF);
                end
                2: begin
                    write_reg(CFG_NUM_STATES, FL_W'(15));
                    write_reg(CFG_RATE_FLOOR, FL_W'(0));
                end
                3: begin
                    write_reg(CFG_NUM_STATES, FL_W'(8));
                    write_reg(CFG_RATE_FLOOR, FL_W'(17));
                end
                default: begin
                    write_reg(CFG_NUM_STATES, FL_W'($urandom_range(0, 15)));
                    write_reg(CFG_RATE_FLOOR, FL_W'($urandom));
                end
            endcase
            for (int k = 0; k < 50; k++) begin
                r = $urandom_range(0, 99);
                if (r < 40) send_item(ACT_DWELL, $urandom_range(0, 7), $urandom_range(0, 7),
                                      rand_amount(), k % 10 < 3);
                else if (r < 78) send_item(ACT_TRANS, $urandom_range(0, 7),
                                           $urandom_range(0, 7), rand_amount(), k % 10 < 3);
                else if (r < 96) send_item(ACT_EST, $urandom_range(0, 7),
                                           $urandom_range(0, 7), $urandom);
                else send_item(ACT_CLEAR, $urandom_range(0, 7), $urandom_range(0, 7), $urandom);
                if (k == 25 && ph == 5) drain_rows();
            end
            drain_rows();
        end

        @(posedge i_clk iff rates_waiting == 0);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0) $display("No mismatches found");
        else $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire

// ===== filelist.f =====
hdl/mrme_pkg.sv
hdl/mrme_mem.sv
hdl/mrme_div.sv
hdl/markov_rate_matrix_estimator.sv
sim/mrme_checker.sv
sim/tb.sv
